// ===== src/mlas_pkg.sv =====
`timescale 1ns / 1ps
// Package for the multi-literal automaton scanner.
// Holds field widths, item and state codes and the memory request structs; no dependencies.
package mlas_pkg;

  localparam int STATES_DEF    = 1024;
  localparam int LIST_DEF      = 2048;
  localparam int LITERALS_DEF  = 1024;
  localparam int MAX_HITS_DEF  = 16;

  localparam int SYMBOL_BITS   = 8;
  localparam int MAX_RESULTS   = 16;

  localparam int KIND_W        = 3;
  localparam int TSTATE_W      = 10;
  localparam int TIDX_W        = 11;
  localparam int TVAL_W        = 12;
  localparam int LIT_W         = 10;
  localparam int CNT_W         = 32;

  localparam logic RK_MATCH    = 1'b0;
  localparam logic RK_TOTAL    = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_TRANS  = 3'd0,
    KIND_LOAD_OFFSET = 3'd1,
    KIND_LOAD_LIST   = 3'd2,
    KIND_BEGIN       = 3'd3,
    KIND_BYTE        = 3'd4,
    KIND_END         = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRANS,
    ST_OFFS,
    ST_WALK,
    ST_END
  } state_e;

  typedef struct packed {
    logic trans_we;
    logic offs_we;
    logic list_we;
  } wr_req_t;

  typedef struct packed {
    logic trans_re;
    logic offs_re;
    logic list_re;
  } rd_req_t;

endpackage

// ===== src/multi_literal_automaton_scanner_top.sv =====
`timescale 1ns / 1ps
// Multi-literal scanner driven by a loaded Aho-Corasick automaton.
// One input channel of load, begin, byte and end items; one output channel of
// match and total reports, each a valid/ready pair with the payload on its own ports.
// Load and begin items leave the block idle. A scan byte first reads the
// transition memory and ends there when it is skipped at the root; else it reads
// the offset memory and ends when its new state has no matches, and otherwise it
// walks the literal list with one read per match into a single output register.
// These reads are registered; the offset memory is read at two addresses at once.
// An end item waits for the output register and reports the saturating match count.
// At most the smaller of MAX_HITS_PER_STATE and 16 matches are reported per byte.
// Reset returns the automaton to the root and clears the position and count;
// the table memories are not cleared and must be loaded before a scan.
// When the receiver stalls, the output register holds its report and the match
// walk waits before its next list read; while the block is idle, input items are
// still taken as a report waits.
// Depends on mlas_pkg, mlas_ctrl and mlas_tables.
module multi_literal_automaton_scanner_top #(
  parameter int STATES             = mlas_pkg::STATES_DEF,
  parameter int LIST_ENTRIES       = mlas_pkg::LIST_DEF,
  parameter int LITERALS           = mlas_pkg::LITERALS_DEF,
  parameter int MAX_HITS_PER_STATE = mlas_pkg::MAX_HITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mlas_pkg::KIND_W-1:0]      kind_i,
  input  logic [mlas_pkg::TSTATE_W-1:0]    table_state_i,
  input  logic [mlas_pkg::SYMBOL_BITS-1:0] table_symbol_i,
  input  logic [mlas_pkg::TIDX_W-1:0]      table_index_i,
  input  logic [mlas_pkg::TVAL_W-1:0]      table_value_i,
  input  logic [mlas_pkg::SYMBOL_BITS-1:0] data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             result_kind_o,
  output logic [mlas_pkg::CNT_W-1:0]       match_end_o,
  output logic [mlas_pkg::LIT_W-1:0]       literal_id_o,
  output logic [mlas_pkg::CNT_W-1:0]       total_hits_o,
  output logic                             last_o
);
  import mlas_pkg::*;

  localparam int SW  = $clog2(STATES);
  localparam int TAW = SW + SYMBOL_BITS;
  localparam int OAW = $clog2(STATES + 1);
  localparam int OVW = $clog2(LIST_ENTRIES + 1);
  localparam int LAW = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;

  wr_req_t          wr;
  rd_req_t          rd;
  logic [TAW-1:0]   trans_waddr;
  logic [SW-1:0]    trans_wdata;
  logic [TAW-1:0]   trans_raddr;
  logic [SW-1:0]    trans_rdata;
  logic [OAW-1:0]   offs_waddr;
  logic [OVW-1:0]   offs_wdata;
  logic [OAW-1:0]   offs_raddr_a;
  logic [OAW-1:0]   offs_raddr_b;
  logic [OVW-1:0]   offs_rdata_a;
  logic [OVW-1:0]   offs_rdata_b;
  logic [LAW-1:0]   list_waddr;
  logic [LIT_W-1:0] list_wdata;
  logic [LAW-1:0]   list_raddr;
  logic [LIT_W-1:0] list_rdata;

  mlas_ctrl #(
    .STATES             (STATES),
    .LIST_ENTRIES       (LIST_ENTRIES),
    .LITERALS           (LITERALS),
    .MAX_HITS_PER_STATE (MAX_HITS_PER_STATE)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .table_state_i  (table_state_i),
    .table_symbol_i (table_symbol_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .match_end_o    (match_end_o),
    .literal_id_o   (literal_id_o),
    .total_hits_o   (total_hits_o),
    .last_o         (last_o),
    .wr_o           (wr),
    .rd_o           (rd),
    .trans_waddr_o  (trans_waddr),
    .trans_wdata_o  (trans_wdata),
    .trans_raddr_o  (trans_raddr),
    .trans_rdata_i  (trans_rdata),
    .offs_waddr_o   (offs_waddr),
    .offs_wdata_o   (offs_wdata),
    .offs_raddr_a_o (offs_raddr_a),
    .offs_raddr_b_o (offs_raddr_b),
    .offs_rdata_a_i (offs_rdata_a),
    .offs_rdata_b_i (offs_rdata_b),
    .list_waddr_o   (list_waddr),
    .list_wdata_o   (list_wdata),
    .list_raddr_o   (list_raddr),
    .list_rdata_i   (list_rdata)
  );

  mlas_tables #(
    .STATES       (STATES),
    .LIST_ENTRIES (LIST_ENTRIES)
  ) u_tables (
    .clk_i          (clk_i),
    .wr_i           (wr),
    .rd_i           (rd),
    .trans_waddr_i  (trans_waddr),
    .trans_wdata_i  (trans_wdata),
    .trans_raddr_i  (trans_raddr),
    .trans_rdata_o  (trans_rdata),
    .offs_waddr_i   (offs_waddr),
    .offs_wdata_i   (offs_wdata),
    .offs_raddr_a_i (offs_raddr_a),
    .offs_raddr_b_i (offs_raddr_b),
    .offs_rdata_a_o (offs_rdata_a),
    .offs_rdata_b_o (offs_rdata_b),
    .list_waddr_i   (list_waddr),
    .list_wdata_i   (list_wdata),
    .list_raddr_i   (list_raddr),
    .list_rdata_o   (list_rdata)
  );

endmodule

// ===== src/mlas_tables.sv =====
`timescale 1ns / 1ps
// Table memories of the scanner: transition table, list offsets and literal list.
// Synchronous write and registered read ports; uses mlas_pkg request structs.
module mlas_tables #(
  parameter int STATES       = mlas_pkg::STATES_DEF,
  parameter int LIST_ENTRIES = mlas_pkg::LIST_DEF
) (
  input  logic               clk_i,
  input  mlas_pkg::wr_req_t  wr_i,
  input  mlas_pkg::rd_req_t  rd_i,
  input  logic [$clog2(STATES)+mlas_pkg::SYMBOL_BITS-1:0] trans_waddr_i,
  input  logic [$clog2(STATES)-1:0]                       trans_wdata_i,
  input  logic [$clog2(STATES)+mlas_pkg::SYMBOL_BITS-1:0] trans_raddr_i,
  output logic [$clog2(STATES)-1:0]                       trans_rdata_o,
  input  logic [$clog2(STATES+1)-1:0]                     offs_waddr_i,
  input  logic [$clog2(LIST_ENTRIES+1)-1:0]               offs_wdata_i,
  input  logic [$clog2(STATES+1)-1:0]                     offs_raddr_a_i,
  input  logic [$clog2(STATES+1)-1:0]                     offs_raddr_b_i,
  output logic [$clog2(LIST_ENTRIES+1)-1:0]               offs_rdata_a_o,
  output logic [$clog2(LIST_ENTRIES+1)-1:0]               offs_rdata_b_o,
  input  logic [((LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1)-1:0] list_waddr_i,
  input  logic [mlas_pkg::LIT_W-1:0]                      list_wdata_i,
  input  logic [((LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1)-1:0] list_raddr_i,
  output logic [mlas_pkg::LIT_W-1:0]                      list_rdata_o
);
  import mlas_pkg::*;

  localparam int SW  = $clog2(STATES);
  localparam int OVW = $clog2(LIST_ENTRIES + 1);
  localparam int TRANS_DEPTH = STATES * (2 ** SYMBOL_BITS);

  logic [SW-1:0]    trans_mem [TRANS_DEPTH];
  logic [OVW-1:0]   offs_mem  [STATES + 1];
  logic [LIT_W-1:0] list_mem  [LIST_ENTRIES];

  logic [SW-1:0]    trans_rdata_q;
  logic [OVW-1:0]   offs_rdata_a_q;
  logic [OVW-1:0]   offs_rdata_b_q;
  logic [LIT_W-1:0] list_rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.trans_we) begin
      trans_mem[trans_waddr_i] <= trans_wdata_i;
    end
    if (rd_i.trans_re) begin
      trans_rdata_q <= trans_mem[trans_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.offs_we) begin
      offs_mem[offs_waddr_i] <= offs_wdata_i;
    end
    if (rd_i.offs_re) begin
      offs_rdata_a_q <= offs_mem[offs_raddr_a_i];
      offs_rdata_b_q <= offs_mem[offs_raddr_b_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.list_we) begin
      list_mem[list_waddr_i] <= list_wdata_i;
    end
    if (rd_i.list_re) begin
      list_rdata_q <= list_mem[list_raddr_i];
    end
  end

  assign trans_rdata_o  = trans_rdata_q;
  assign offs_rdata_a_o = offs_rdata_a_q;
  assign offs_rdata_b_o = offs_rdata_b_q;
  assign list_rdata_o   = list_rdata_q;

endmodule

// ===== src/mlas_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the scanner: decodes items, steps the automaton and walks match lists.
// Drives the table memories in mlas_tables; uses mlas_pkg codes and structs.
module mlas_ctrl #(
  parameter int STATES             = mlas_pkg::STATES_DEF,
  parameter int LIST_ENTRIES       = mlas_pkg::LIST_DEF,
  parameter int LITERALS           = mlas_pkg::LITERALS_DEF,
  parameter int MAX_HITS_PER_STATE = mlas_pkg::MAX_HITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mlas_pkg::KIND_W-1:0]   kind_i,
  input  logic [mlas_pkg::TSTATE_W-1:0] table_state_i,
  input  logic [mlas_pkg::SYMBOL_BITS-1:0] table_symbol_i,
  input  logic [mlas_pkg::TIDX_W-1:0]   table_index_i,
  input  logic [mlas_pkg::TVAL_W-1:0]   table_value_i,
  input  logic [mlas_pkg::SYMBOL_BITS-1:0] data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          result_kind_o,
  output logic [mlas_pkg::CNT_W-1:0]    match_end_o,
  output logic [mlas_pkg::LIT_W-1:0]    literal_id_o,
  output logic [mlas_pkg::CNT_W-1:0]    total_hits_o,
  output logic                          last_o,
  output mlas_pkg::wr_req_t             wr_o,
  output mlas_pkg::rd_req_t             rd_o,
  output logic [$clog2(STATES)+mlas_pkg::SYMBOL_BITS-1:0] trans_waddr_o,
  output logic [$clog2(STATES)-1:0]                       trans_wdata_o,
  output logic [$clog2(STATES)+mlas_pkg::SYMBOL_BITS-1:0] trans_raddr_o,
  input  logic [$clog2(STATES)-1:0]                       trans_rdata_i,
  output logic [$clog2(STATES+1)-1:0]                     offs_waddr_o,
  output logic [$clog2(LIST_ENTRIES+1)-1:0]               offs_wdata_o,
  output logic [$clog2(STATES+1)-1:0]                     offs_raddr_a_o,
  output logic [$clog2(STATES+1)-1:0]                     offs_raddr_b_o,
  input  logic [$clog2(LIST_ENTRIES+1)-1:0]               offs_rdata_a_i,
  input  logic [$clog2(LIST_ENTRIES+1)-1:0]               offs_rdata_b_i,
  output logic [((LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1)-1:0] list_waddr_o,
  output logic [mlas_pkg::LIT_W-1:0]                      list_wdata_o,
  output logic [((LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1)-1:0] list_raddr_o,
  input  logic [mlas_pkg::LIT_W-1:0]                      list_rdata_i
);
  import mlas_pkg::*;

  localparam int SW  = $clog2(STATES);
  localparam int OAW = $clog2(STATES + 1);
  localparam int OVW = $clog2(LIST_ENTRIES + 1);
  localparam int LAW = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
  localparam int CAP = (MAX_HITS_PER_STATE < MAX_RESULTS) ? MAX_HITS_PER_STATE : MAX_RESULTS;
  localparam int NW  = $clog2(CAP + 1);

  state_e           state_q, state_d;
  logic [SW-1:0]    node_q, node_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] hits_q, hits_d;
  logic [OVW-1:0]   ptr_q, ptr_d;
  logic [NW-1:0]    rem_q, rem_d;
  logic             inflight_q, inflight_d;
  logic             issued_last_q, issued_last_d;

  logic             out_valid_q, out_valid_d;
  logic             out_kind_q, out_kind_d;
  logic [CNT_W-1:0] out_end_q, out_end_d;
  logic [LIT_W-1:0] out_lit_q, out_lit_d;
  logic [CNT_W-1:0] out_tot_q, out_tot_d;
  logic             out_last_q, out_last_d;
  logic             out_load;

  kind_e            in_kind;
  logic             accept;
  logic             root_skip;
  logic [SW-1:0]    nxt_fix;
  logic [OVW-1:0]   diff;
  logic [NW-1:0]    hits_n;
  logic [CNT_W:0]   hits_sum;
  logic             out_free;
  logic             issue;

  assign in_kind    = kind_e'(kind_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign root_skip  = (node_q == '0) && (trans_rdata_i == '0);
  assign nxt_fix    = (32'(trans_rdata_i) >= 32'(STATES)) ? '0 : trans_rdata_i;
  assign diff       = (offs_rdata_b_i > offs_rdata_a_i) ? (offs_rdata_b_i - offs_rdata_a_i) : '0;
  assign hits_n     = (32'(diff) > 32'(CAP)) ? NW'(CAP) : NW'(diff);
  assign hits_sum   = {1'b0, hits_q} + (CNT_W + 1)'(hits_n);
  assign out_free   = !out_valid_q || out_ready_i;
  assign issue      = (state_q == ST_WALK) && !inflight_q && out_free && (rem_q != '0);

  always_comb begin
    wr_o = '0;
    trans_waddr_o = {SW'(table_state_i), table_symbol_i};
    trans_wdata_o = SW'(table_value_i);
    offs_waddr_o  = OAW'(table_index_i);
    offs_wdata_o  = (32'(table_value_i) > 32'(LIST_ENTRIES)) ? OVW'(LIST_ENTRIES)
                                                             : OVW'(table_value_i);
    list_waddr_o  = LAW'(table_index_i);
    list_wdata_o  = LIT_W'(table_value_i);
    if (accept) begin
      unique case (in_kind)
        KIND_LOAD_TRANS: begin
          wr_o.trans_we = (32'(table_state_i) < 32'(STATES)) &&
                          (32'(table_value_i) < 32'(STATES));
        end
        KIND_LOAD_OFFSET: begin
          wr_o.offs_we = (32'(table_index_i) <= 32'(STATES));
        end
        KIND_LOAD_LIST: begin
          wr_o.list_we = (32'(table_index_i) < 32'(LIST_ENTRIES)) &&
                         (32'(table_value_i) < 32'(LITERALS));
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_BYTE: state_d = ST_TRANS;
            KIND_END:  state_d = ST_END;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_TRANS: state_d = root_skip ? ST_IDLE : ST_OFFS;
      ST_OFFS:  state_d = (hits_n == '0) ? ST_IDLE : ST_WALK;
      ST_WALK: begin
        if (inflight_q && issued_last_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_END: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    node_d        = node_q;
    pos_d         = pos_q;
    hits_d        = hits_q;
    ptr_d         = ptr_q;
    rem_d         = rem_q;
    inflight_d    = 1'b0;
    issued_last_d = issued_last_q;
    rd_o          = '0;
    trans_raddr_o = {node_q, data_byte_i};
    offs_raddr_a_o = OAW'(nxt_fix);
    offs_raddr_b_o = OAW'(nxt_fix) + OAW'(1);
    list_raddr_o  = LAW'(ptr_q);
    out_load      = 1'b0;
    out_kind_d    = RK_MATCH;
    out_end_d     = pos_q;
    out_lit_d     = list_rdata_i;
    out_tot_d     = '0;
    out_last_d    = issued_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_BEGIN: begin
              node_d = '0;
              pos_d  = '0;
              hits_d = '0;
            end
            KIND_BYTE: begin
              rd_o.trans_re = 1'b1;
              pos_d = pos_q + CNT_W'(1);
            end
            default: begin
            end
          endcase
        end
      end
      ST_TRANS: begin
        if (!root_skip) begin
          node_d = nxt_fix;
          rd_o.offs_re = 1'b1;
        end
      end
      ST_OFFS: begin
        ptr_d  = offs_rdata_a_i;
        rem_d  = hits_n;
        hits_d = hits_sum[CNT_W] ? '1 : hits_sum[CNT_W-1:0];
      end
      ST_WALK: begin
        if (issue) begin
          rd_o.list_re  = 1'b1;
          ptr_d         = ptr_q + OVW'(1);
          rem_d         = rem_q - NW'(1);
          inflight_d    = 1'b1;
          issued_last_d = (rem_q == NW'(1));
        end
        if (inflight_q) begin
          out_load = 1'b1;
        end
      end
      ST_END: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = RK_TOTAL;
          out_end_d  = '0;
          out_lit_d  = '0;
          out_tot_d  = hits_q;
          out_last_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      node_q      <= '0;
      pos_q       <= '0;
      hits_q      <= '0;
      inflight_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      pos_q       <= pos_d;
      hits_q      <= hits_d;
      inflight_q  <= inflight_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q         <= ptr_d;
    rem_q         <= rem_d;
    issued_last_q <= issued_last_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_end_q  <= out_end_d;
      out_lit_q  <= out_lit_d;
      out_tot_q  <= out_tot_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign match_end_o   = out_end_q;
  assign literal_id_o  = out_lit_q;
  assign total_hits_o  = out_tot_q;
  assign last_o        = out_last_q;

`ifndef SYNTHESIS
  a_inflight_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q |-> !out_valid_q)
    else $error("list read in flight while the output register is still full");

  a_walk_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) && inflight_q && issued_last_q |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("walk did not end after its last match");

  a_byte_reads_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_kind == KIND_BYTE) |=> (state_q == ST_TRANS))
    else $error("scan byte did not start a transition read");

  a_walk_count_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (32'(rem_q) <= 32'(CAP)))
    else $error("match walk longer than the per-state cap");
`endif

endmodule

// ===== dv/mlas_report_checker.sv =====
`timescale 1ns / 1ps
// Report checker for the multi-literal automaton scanner testbench.
// Mirrors the tables, automaton state and counters from accepted items, queues the
// reports each item should cause and compares every accepted report; needs mlas_pkg.
module mlas_report_checker #(
  parameter int STATES             = mlas_pkg::STATES_DEF,
  parameter int LIST_ENTRIES       = mlas_pkg::LIST_DEF,
  parameter int LITERALS           = mlas_pkg::LITERALS_DEF,
  parameter int MAX_HITS_PER_STATE = mlas_pkg::MAX_HITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [mlas_pkg::KIND_W-1:0]      kind_i,
  input  logic [mlas_pkg::TSTATE_W-1:0]    table_state_i,
  input  logic [mlas_pkg::SYMBOL_BITS-1:0] table_symbol_i,
  input  logic [mlas_pkg::TIDX_W-1:0]      table_index_i,
  input  logic [mlas_pkg::TVAL_W-1:0]      table_value_i,
  input  logic [mlas_pkg::SYMBOL_BITS-1:0] data_byte_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic                             result_kind_i,
  input  logic [mlas_pkg::CNT_W-1:0]       match_end_i,
  input  logic [mlas_pkg::LIT_W-1:0]       literal_id_i,
  input  logic [mlas_pkg::CNT_W-1:0]       total_hits_i,
  input  logic                             last_i,
  output int                               mismatches_o,
  output int                               pending_o,
  output int                               reports_o
);
  import mlas_pkg::*;

  localparam int HIT_CAP = (MAX_HITS_PER_STATE < MAX_RESULTS) ? MAX_HITS_PER_STATE
                                                              : MAX_RESULTS;

  typedef struct packed {
    logic             rk;
    logic [CNT_W-1:0] end_pos;
    logic [LIT_W-1:0] lit;
    logic [CNT_W-1:0] total;
    logic             last;
  } report_t;

  logic [TSTATE_W-1:0] next_state_mem [0:(STATES << SYMBOL_BITS)-1];
  logic [TVAL_W-1:0]   offset_mem [0:STATES];
  logic [LIT_W-1:0]    literal_mem [0:LIST_ENTRIES-1];
  logic [TSTATE_W-1:0] node;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    hits;
  report_t             expected_reports [$];
  int                  mismatch_count = 0;
  int                  pending_count = 0;
  int                  reports_seen = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;
  assign reports_o    = reports_seen;

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  task automatic predict_reports(input logic [KIND_W-1:0] kind,
                                 input logic [TSTATE_W-1:0] tstate,
                                 input logic [SYMBOL_BITS-1:0] tsym,
                                 input logic [TIDX_W-1:0] tidx,
                                 input logic [TVAL_W-1:0] tval,
                                 input logic [SYMBOL_BITS-1:0] dbyte);
    int src;
    int dst;
    int lo;
    int hi;
    int n;
    logic [CNT_W-1:0] here;
    report_t rep;
    case (kind)
      KIND_LOAD_TRANS: begin
        if (int'(tstate) < STATES && int'(tval) < STATES) begin
          next_state_mem[(int'(tstate) << SYMBOL_BITS) | int'(tsym)] = tval[TSTATE_W-1:0];
        end
      end
      KIND_LOAD_OFFSET: begin
        if (int'(tidx) <= STATES) begin
          offset_mem[tidx] = (int'(tval) > LIST_ENTRIES) ? TVAL_W'(LIST_ENTRIES) : tval;
        end
      end
      KIND_LOAD_LIST: begin
        if (int'(tidx) < LIST_ENTRIES && int'(tval) < LITERALS) begin
          literal_mem[tidx] = tval[LIT_W-1:0];
        end
      end
      KIND_BEGIN: begin
        node = '0;
        pos  = '0;
        hits = '0;
      end
      KIND_BYTE: begin
        src  = (int'(node) < STATES) ? int'(node) : 0;
        dst  = int'(next_state_mem[(src << SYMBOL_BITS) | int'(dbyte)]);
        here = pos + 1;
        pos  = here;
        if (!(src == 0 && dst == 0)) begin
          if (dst >= STATES) dst = 0;
          node = dst[TSTATE_W-1:0];
          lo = int'(offset_mem[dst]);
          hi = int'(offset_mem[dst + 1]);
          if (hi > LIST_ENTRIES) hi = LIST_ENTRIES;
          n = (hi > lo) ? hi - lo : 0;
          if (n > HIT_CAP) n = HIT_CAP;
          for (int k = 0; k < n; k++) begin
            rep.rk      = RK_MATCH;
            rep.end_pos = here;
            rep.lit     = literal_mem[lo + k];
            rep.total   = '0;
            rep.last    = (k == n - 1);
            expected_reports.push_back(rep);
          end
          if (longint'(hits) + n > 64'h0000_0000_FFFF_FFFF) hits = '1;
          else hits = hits + n;
        end
      end
      KIND_END: begin
        rep.rk      = RK_TOTAL;
        rep.end_pos = '0;
        rep.lit     = '0;
        rep.total   = hits;
        rep.last    = 1'b1;
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      node = '0;
      pos  = '0;
      hits = '0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_reports(kind_i, table_state_i, table_symbol_i, table_index_i,
                        table_value_i, data_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          flag_mismatch($sformatf("report %0d arrived with none expected (kind %0d)",
                                  reports_seen, result_kind_i));
        end else begin
          want = expected_reports.pop_front();
          if (result_kind_i !== want.rk)
            flag_mismatch($sformatf("report %0d: result_kind %0d, expected %0d",
                                    reports_seen, result_kind_i, want.rk));
          if (match_end_i !== want.end_pos)
            flag_mismatch($sformatf("report %0d: match_end %0d, expected %0d",
                                    reports_seen, match_end_i, want.end_pos));
          if (literal_id_i !== want.lit)
            flag_mismatch($sformatf("report %0d: literal_id %0d, expected %0d",
                                    reports_seen, literal_id_i, want.lit));
          if (total_hits_i !== want.total)
            flag_mismatch($sformatf("report %0d: total_hits %0d, expected %0d",
                                    reports_seen, total_hits_i, want.total));
          if (last_i !== want.last)
            flag_mismatch($sformatf("report %0d: last %0d, expected %0d",
                                    reports_seen, last_i, want.last));
        end
      end
      pending_count = expected_reports.size();
    end
  end

endmodule

// ===== dv/tb_multi_literal_automaton_scanner_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the multi-literal automaton scanner: clock, reset, table loading,
// directed and random scans with random idling on both channels, and the verdict.
// Depends on mlas_pkg, multi_literal_automaton_scanner_top and mlas_report_checker.
module tb_multi_literal_automaton_scanner_top;
  import mlas_pkg::*;

  localparam int STATES       = STATES_DEF;
  localparam int LIST_ENTRIES = LIST_DEF;
  localparam int LITERALS     = LITERALS_DEF;
  localparam int LIVE_STATES  = 6;
  localparam int ALPHA_SIZE   = 6;
  localparam int OFFSET_MAX   = 32;
  localparam int LIST_WINDOW  = OFFSET_MAX + MAX_RESULTS;
  localparam int LIST_TAIL    = 8;
  localparam int ITEM_TARGET  = 180;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int VALUE_MAX    = 2048;
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [KIND_W-1:0]      kind;
  logic [TSTATE_W-1:0]    tbl_state;
  logic [SYMBOL_BITS-1:0] tbl_symbol;
  logic [TIDX_W-1:0]      tbl_index;
  logic [TVAL_W-1:0]      tbl_value;
  logic [SYMBOL_BITS-1:0] data_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic                   result_kind;
  logic [CNT_W-1:0]       match_end;
  logic [LIT_W-1:0]       literal_id;
  logic [CNT_W-1:0]       total_hits;
  logic                   last;

  int mismatches;
  int pending;
  int reports;
  int items_sent = 0;
  int scans_ended = 0;
  int quiet_cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  logic [TSTATE_W-1:0]    live [LIVE_STATES];
  logic [SYMBOL_BITS-1:0] alpha [ALPHA_SIZE];

  multi_literal_automaton_scanner_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .table_state_i  (tbl_state),
    .table_symbol_i (tbl_symbol),
    .table_index_i  (tbl_index),
    .table_value_i  (tbl_value),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind),
    .match_end_o    (match_end),
    .literal_id_o   (literal_id),
    .total_hits_o   (total_hits),
    .last_o         (last)
  );

  mlas_report_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .kind_i         (kind),
    .table_state_i  (tbl_state),
    .table_symbol_i (tbl_symbol),
    .table_index_i  (tbl_index),
    .table_value_i  (tbl_value),
    .data_byte_i    (data_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_i  (result_kind),
    .match_end_i    (match_end),
    .literal_id_i   (literal_id),
    .total_hits_i   (total_hits),
    .last_i         (last),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .reports_o      (reports)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 6) : 0;
      @(negedge clk);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] k, input int st, input int sym,
                           input int idx, input int val, input int dbyte);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    kind       = k;
    tbl_state  = st[TSTATE_W-1:0];
    tbl_symbol = sym[SYMBOL_BITS-1:0];
    tbl_index  = idx[TIDX_W-1:0];
    tbl_value  = val[TVAL_W-1:0];
    data_byte  = dbyte[SYMBOL_BITS-1:0];
    if (k != KIND_SPARE_A && k != KIND_SPARE_B) items_sent++;
    if (k == KIND_END) scans_ended++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_plain(input logic [KIND_W-1:0] k);
    send_item(k, $urandom_range(0, STATES - 1), $urandom_range(0, 255),
              $urandom_range(0, 2047), $urandom_range(0, VALUE_MAX), $urandom_range(0, 255));
  endtask

  task automatic load_trans(input int st, input int sym, input int tgt);
    send_item(KIND_LOAD_TRANS, st, sym, $urandom_range(0, 2047), tgt, $urandom_range(0, 255));
  endtask

  task automatic load_offset(input int idx, input int val);
    send_item(KIND_LOAD_OFFSET, $urandom_range(0, STATES - 1), $urandom_range(0, 255),
              idx, val, $urandom_range(0, 255));
  endtask

  task automatic load_list(input int idx, input int val);
    send_item(KIND_LOAD_LIST, $urandom_range(0, STATES - 1), $urandom_range(0, 255),
              idx, val, $urandom_range(0, 255));
  endtask

  task automatic scan_byte(input int b);
    send_item(KIND_BYTE, $urandom_range(0, STATES - 1), $urandom_range(0, 255),
              $urandom_range(0, 2047), $urandom_range(0, VALUE_MAX), b);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_noise();
    int tgt;
    case ($urandom_range(0, 3))
      0: begin
        tgt = ($urandom_range(0, 6) == 0) ? $urandom_range(STATES, VALUE_MAX)
                                          : live[$urandom_range(0, LIVE_STATES - 1)];
        load_trans(live[$urandom_range(0, LIVE_STATES - 1)], $urandom_range(0, 255), tgt);
      end
      1: load_offset($urandom_range(0, 2047),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(LIST_ENTRIES, VALUE_MAX)
                                                 : $urandom_range(0, OFFSET_MAX));
      2: load_list($urandom_range(0, LIST_ENTRIES - 1), $urandom_range(0, VALUE_MAX));
      default: send_plain($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B);
    endcase
  endtask

  initial begin
    int cand;
    int tgt;
    int lo;
    int start_count;
    int seq;
    bit clash;
    bit broken;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    kind       = KIND_BEGIN;
    tbl_state  = '0;
    tbl_symbol = '0;
    tbl_index  = '0;
    tbl_value  = '0;
    data_byte  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reachable states are kept at least two apart so that their list bounds
    // can be set independently.
    live[0] = '0;
    live[1] = TSTATE_W'(STATES - 1);
    for (int i = 2; i < LIVE_STATES; i++) begin
      do begin
        cand  = $urandom_range(2, STATES - 3);
        clash = 1'b0;
        for (int j = 0; j < i; j++) begin
          if (cand >= int'(live[j]) - 1 && cand <= int'(live[j]) + 1) clash = 1'b1;
        end
      end while (clash);
      live[i] = cand[TSTATE_W-1:0];
    end

    // Scan text is drawn from a small alphabet that holds the directed bytes.
    alpha[0] = 8'h00;
    alpha[1] = 8'h01;
    alpha[2] = 8'hFF;
    for (int i = 3; i < ALPHA_SIZE; i++) begin
      alpha[i] = SYMBOL_BITS'($urandom_range(2, 254));
    end

    // Each reachable state's row is written for the whole alphabet, and its list
    // bounds and every list entry those bounds can reach are written before the
    // first scan.
    for (int s = 0; s < LIVE_STATES; s++) begin
      for (int a = 0; a < ALPHA_SIZE; a++) begin
        if (s == 0) begin
          tgt = ($urandom_range(0, 1) == 0) ? live[$urandom_range(1, LIVE_STATES - 1)] : 0;
        end else begin
          tgt = $urandom_range(0, 1) ? live[$urandom_range(0, LIVE_STATES - 1)] : 0;
        end
        load_trans(live[s], alpha[a], tgt);
      end
    end
    for (int s = 0; s < LIVE_STATES; s++) begin
      lo = $urandom_range(0, OFFSET_MAX);
      load_offset(live[s], lo);
      load_offset(live[s] + 1, ($urandom_range(0, 4) == 0) ? $urandom_range(0, OFFSET_MAX)
                                                          : lo + $urandom_range(0, 3));
    end
    for (int i = 0; i < LIST_WINDOW; i++) begin
      load_list(i, $urandom_range(0, LITERALS - 1));
    end
    for (int i = LIST_ENTRIES - LIST_TAIL; i < LIST_ENTRIES; i++) begin
      load_list(i, $urandom_range(0, LITERALS - 1));
    end

    scan_byte(alpha[$urandom_range(0, ALPHA_SIZE - 1)]);
    send_plain(KIND_END);
    load_trans(0, 8'h00, STATES - 1);
    load_trans(0, 8'hFF, live[2]);
    load_trans(0, 8'h01, live[3]);
    load_trans(0, 8'h00, VALUE_MAX);
    load_offset(STATES - 1, LIST_ENTRIES - LIST_TAIL);
    load_offset(STATES, VALUE_MAX);
    load_offset(live[2], 4);
    load_offset(live[2] + 1, 30);
    load_offset(live[3], 20);
    load_offset(live[3] + 1, 12);
    load_offset(2047, 0);
    load_list(LIST_ENTRIES - 1, LITERALS - 1);
    load_list(5, VALUE_MAX);
    send_plain(KIND_SPARE_A);
    send_plain(KIND_SPARE_B);
    send_plain(KIND_BEGIN);
    scan_byte(8'h00);
    scan_byte(alpha[$urandom_range(0, ALPHA_SIZE - 1)]);
    send_plain(KIND_END);
    send_plain(KIND_BEGIN);
    scan_byte(8'hFF);
    send_plain(KIND_BEGIN);
    scan_byte(8'h01);
    send_plain(KIND_END);
    wait_drained();

    start_count = items_sent;
    seq = 0;
    while (items_sent - start_count < ITEM_TARGET) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) rx_idle_on = !rx_idle_on;
      broken = ($urandom_range(0, 9) == 0);
      if (!broken || $urandom_range(0, 1)) send_plain(KIND_BEGIN);
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        else scan_byte(alpha[$urandom_range(0, ALPHA_SIZE - 1)]);
      end
      if (!broken || $urandom_range(0, 1)) send_plain(KIND_END);
      if (seq % 5 == 0) wait_drained();
      seq++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run summary: %0d items sent (table loads, scans, %0d scan totals asked),",
             items_sent, scans_ended);
    $display("%0d reports checked in %0d random scan sequences.", reports, seq);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mlas_pkg.sv
src/mlas_tables.sv
src/mlas_ctrl.sv
src/multi_literal_automaton_scanner_top.sv
dv/mlas_report_checker.sv
dv/tb_multi_literal_automaton_scanner_top.sv
